// File: rtl/core/qvr_pkg.sv
// Package for the quaternion vector rotation block.
// Holds the fixed-point format constants, the derived datapath widths and the stage control type.
// No dependencies; every other file in rtl/core imports it.
package qvr_pkg;

    localparam int VEC_BITS       = 24;
    localparam int QUAT_FRAC_BITS = 15;

    localparam int Q_W    = QUAT_FRAC_BITS + 1;
    localparam int PR_W   = 2 * Q_W;
    localparam int M_W    = 2 * Q_W + 2;
    localparam int MV_W   = M_W + VEC_BITS;
    localparam int ACC_W  = MV_W + 2;
    localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int RND_W  = ACC_W - SHIFT;

    typedef struct packed {
        logic valid;
    } stage_ctl_t;

endpackage

// File: rtl/core/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation block.
// Chains the matrix, multiply-accumulate and rounding stages.
// Depends on qvr_pkg, qvr_matrix, qvr_mac and qvr_round.
//
//   Channel   Transfer when       Ports
//   -------   -----------------   -------------------------------------------
//   input     start && !busy      quat_w, quat_x, quat_y, quat_z, vec_x..vec_z
//   result    done                rot_x, rot_y, rot_z, clipped
//
// Each item passes through five pipeline register stages (products, matrix,
// row products, row sums, round) between transfer and done. While busy is low,
// a new item may be transferred in every cycle; results leave in input order.
// busy is high only during reset and the first cycle after it.
// The receiver cannot stall, so the pipeline never holds and never drops items.
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [Q_W-1:0]      quat_w,
    input  logic signed [Q_W-1:0]      quat_x,
    input  logic signed [Q_W-1:0]      quat_y,
    input  logic signed [Q_W-1:0]      quat_z,
    input  logic signed [VEC_BITS-1:0] vec_x,
    input  logic signed [VEC_BITS-1:0] vec_y,
    input  logic signed [VEC_BITS-1:0] vec_z,
    output logic                       done,
    output logic signed [VEC_BITS-1:0] rot_x,
    output logic signed [VEC_BITS-1:0] rot_y,
    output logic signed [VEC_BITS-1:0] rot_z,
    output logic                       clipped
);

    logic busy_reg, busy_next;
    stage_ctl_t in_ctl, mat_ctl, mac_ctl, rnd_ctl;
    logic signed [VEC_BITS-1:0] vin [3];
    logic signed [VEC_BITS-1:0] vmat [3];
    logic signed [M_W-1:0]      mat [3][3];
    logic signed [ACC_W-1:0]    acc [3];
    logic signed [VEC_BITS-1:0] rot [3];

    assign busy_next    = 1'b0;
    assign in_ctl.valid = start && !busy_reg;
    assign vin[0]       = vec_x;
    assign vin[1]       = vec_y;
    assign vin[2]       = vec_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    qvr_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (in_ctl),
        .qw      (quat_w),
        .qx      (quat_x),
        .qy      (quat_y),
        .qz      (quat_z),
        .vin     (vin),
        .out_ctl (mat_ctl),
        .mat     (mat),
        .vout    (vmat)
    );

    qvr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (mat_ctl),
        .mat     (mat),
        .vin     (vmat),
        .out_ctl (mac_ctl),
        .acc     (acc)
    );

    qvr_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (mac_ctl),
        .acc     (acc),
        .out_ctl (rnd_ctl),
        .rot     (rot),
        .clip    (clipped)
    );

    assign busy  = busy_reg;
    assign done  = rnd_ctl.valid;
    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

endmodule

// File: rtl/core/qvr_matrix.sv
// Rotation matrix stages: quaternion products, then the nine matrix entries.
// Two register stages; the vector rides along with its quaternion.
// Depends on qvr_pkg.
module qvr_matrix
    import qvr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  stage_ctl_t               in_ctl,
    input  logic signed [Q_W-1:0]    qw,
    input  logic signed [Q_W-1:0]    qx,
    input  logic signed [Q_W-1:0]    qy,
    input  logic signed [Q_W-1:0]    qz,
    input  logic signed [VEC_BITS-1:0] vin [3],
    output stage_ctl_t               out_ctl,
    output logic signed [M_W-1:0]    mat [3][3],
    output logic signed [VEC_BITS-1:0] vout [3]
);

    localparam logic signed [M_W-1:0] ONE = M_W'(64'd1 << SHIFT);

    stage_ctl_t ctl_a_reg, ctl_b_reg;
    logic signed [PR_W-1:0] pr_reg [9];
    logic signed [PR_W-1:0] pr_next [9];
    logic signed [VEC_BITS-1:0] v_a_reg [3];
    logic signed [VEC_BITS-1:0] v_b_reg [3];
    logic signed [M_W-1:0] m_reg [3][3];
    logic signed [M_W-1:0] m_next [3][3];
    logic signed [M_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

    always_comb
    begin
        pr_next[0] = qx * qx;
        pr_next[1] = qy * qy;
        pr_next[2] = qz * qz;
        pr_next[3] = qx * qy;
        pr_next[4] = qx * qz;
        pr_next[5] = qy * qz;
        pr_next[6] = qw * qx;
        pr_next[7] = qw * qy;
        pr_next[8] = qw * qz;
    end

    always_comb
    begin
        xx = M_W'(pr_reg[0]);
        yy = M_W'(pr_reg[1]);
        zz = M_W'(pr_reg[2]);
        xy = M_W'(pr_reg[3]);
        xz = M_W'(pr_reg[4]);
        yz = M_W'(pr_reg[5]);
        wx = M_W'(pr_reg[6]);
        wy = M_W'(pr_reg[7]);
        wz = M_W'(pr_reg[8]);
        m_next[0][0] = ONE - ((yy + zz) <<< 1);
        m_next[0][1] = (xy - wz) <<< 1;
        m_next[0][2] = (xz + wy) <<< 1;
        m_next[1][0] = (xy + wz) <<< 1;
        m_next[1][1] = ONE - ((xx + zz) <<< 1);
        m_next[1][2] = (yz - wx) <<< 1;
        m_next[2][0] = (xz - wy) <<< 1;
        m_next[2][1] = (yz + wx) <<< 1;
        m_next[2][2] = ONE - ((xx + yy) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg  <= pr_next;
        v_a_reg <= vin;
        m_reg   <= m_next;
        v_b_reg <= v_a_reg;
    end

    assign out_ctl = ctl_b_reg;
    assign mat     = m_reg;
    assign vout    = v_b_reg;

endmodule

// File: rtl/core/qvr_mac.sv
// Matrix-vector product stages: nine exact products, then exact row sums.
// Two register stages.
// Depends on qvr_pkg.
module qvr_mac
    import qvr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stage_ctl_t                 in_ctl,
    input  logic signed [M_W-1:0]      mat [3][3],
    input  logic signed [VEC_BITS-1:0] vin [3],
    output stage_ctl_t                 out_ctl,
    output logic signed [ACC_W-1:0]    acc [3]
);

    stage_ctl_t ctl_c_reg, ctl_d_reg;
    logic signed [MV_W-1:0]  p_reg [3][3];
    logic signed [MV_W-1:0]  p_next [3][3];
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_next[r][k] = mat[r][k] * vin[k];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(p_reg[r][0]) + ACC_W'(p_reg[r][1]) + ACC_W'(p_reg[r][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else
        begin
            ctl_c_reg <= in_ctl;
            ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        acc_reg <= acc_next;
    end

    assign out_ctl = ctl_d_reg;
    assign acc     = acc_reg;

endmodule

// File: rtl/core/qvr_round.sv
// Output stage: round half up back to the vector format and saturate.
// One register stage that also forms the clip flag over all three rows.
// Depends on qvr_pkg.
module qvr_round
    import qvr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stage_ctl_t                 in_ctl,
    input  logic signed [ACC_W-1:0]    acc [3],
    output stage_ctl_t                 out_ctl,
    output logic signed [VEC_BITS-1:0] rot [3],
    output logic                       clip
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (SHIFT - 1));
    localparam logic signed [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS - 1){1'b1}}};
    localparam logic signed [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS - 1){1'b0}}};

    stage_ctl_t ctl_e_reg;
    logic signed [VEC_BITS-1:0] rot_reg [3];
    logic signed [VEC_BITS-1:0] rot_next [3];
    logic clip_reg, clip_next;
    logic signed [ACC_W-1:0] rnd [3];
    logic signed [RND_W-1:0] sh [3];
    logic [RND_W-VEC_BITS:0] top_bits [3];

    always_comb
    begin
        clip_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            rnd[r]      = acc[r] + HALF;
            sh[r]       = rnd[r][ACC_W-1:SHIFT];
            top_bits[r] = sh[r][RND_W-1:VEC_BITS-1];
            if ((&top_bits[r]) || !(|top_bits[r]))
            begin
                rot_next[r] = sh[r][VEC_BITS-1:0];
            end
            else
            begin
                clip_next   = 1'b1;
                rot_next[r] = sh[r][RND_W-1] ? VMIN : VMAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg <= '0;
        end
        else
        begin
            ctl_e_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg  <= rot_next;
        clip_reg <= clip_next;
    end

    assign out_ctl = ctl_e_reg;
    assign rot     = rot_reg;
    assign clip    = clip_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for quaternion_vector_rotate.
// It has a scoreboard class with its own fixed-point rotation predictor, plus tasks that drive
// directed and random quaternion/vector transfers. Depends on qvr_pkg and the RTL top level.
module testbench;
    import qvr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [Q_W-1:0]      quat_t;
    typedef logic signed [VEC_BITS-1:0] vec_t;

    typedef struct {
        vec_t x;
        vec_t y;
        vec_t z;
        logic clip;
    } rotation_t;

    localparam longint VEC_MAX = (longint'(1) <<< (VEC_BITS - 1)) - 1;
    localparam longint VEC_MIN = -VEC_MAX - 1;
    localparam int     GAP_PCT = 11;

    class rotation_checker;
        rotation_t   expected_q[$];
        int unsigned mismatches;
        int unsigned transfers_in;
        int unsigned results_seen;
        int unsigned clip_count;

        function rotation_t predict(quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                                    vec_t vx, vec_t vy, vec_t vz);
            longint    w, x, y, z, one, acc, rnd;
            longint    m[3][3];
            longint    v[3];
            vec_t      comp[3];
            rotation_t res;
            w = qw;
            x = qx;
            y = qy;
            z = qz;
            one = longint'(1) <<< SHIFT;
            v[0] = vx;
            v[1] = vy;
            v[2] = vz;
            m[0][0] = one - 2 * (y * y + z * z);
            m[0][1] = 2 * (x * y - w * z);
            m[0][2] = 2 * (x * z + w * y);
            m[1][0] = 2 * (x * y + w * z);
            m[1][1] = one - 2 * (x * x + z * z);
            m[1][2] = 2 * (y * z - w * x);
            m[2][0] = 2 * (x * z - w * y);
            m[2][1] = 2 * (y * z + w * x);
            m[2][2] = one - 2 * (x * x + y * y);
            res.clip = 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                acc = m[r][0] * v[0] + m[r][1] * v[1] + m[r][2] * v[2];
                rnd = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
                if (rnd > VEC_MAX)
                begin
                    comp[r] = vec_t'(VEC_MAX);
                    res.clip = 1'b1;
                end
                else if (rnd < VEC_MIN)
                begin
                    comp[r] = vec_t'(VEC_MIN);
                    res.clip = 1'b1;
                end
                else
                begin
                    comp[r] = vec_t'(rnd);
                end
            end
            res.x = comp[0];
            res.y = comp[1];
            res.z = comp[2];
            return res;
        endfunction

        function void note_input(quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                                 vec_t vx, vec_t vy, vec_t vz);
            rotation_t res;
            res = predict(qw, qx, qy, qz, vx, vy, vz);
            if (res.clip)
                clip_count++;
            transfers_in++;
            expected_q.push_back(res);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(vec_t rx, vec_t ry, vec_t rz, logic clip);
            rotation_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no transfer pending, expected none, %s %0d %0d %0d %0d",
                         $time, "actual", rx, ry, rz, clip);
            end
            else
            begin
                want = expected_q.pop_front();
                compare("rot_x", want.x, rx);
                compare("rot_y", want.y, ry);
                compare("rot_z", want.z, rz);
                compare("clipped", want.clip, clip);
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    quat_t quat_w, quat_x, quat_y, quat_z;
    vec_t  vec_x, vec_y, vec_z;
    logic  done;
    vec_t  rot_x, rot_y, rot_z;
    logic  clipped;

    rotation_checker chk = new();

    quaternion_vector_rotate dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .vec_x   (vec_x),
        .vec_y   (vec_y),
        .vec_z   (vec_z),
        .done    (done),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .rot_z   (rot_z),
        .clipped (clipped)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                chk.check_result(rot_x, rot_y, rot_z, clipped);
            if (start && !busy)
                chk.note_input(quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z);
        end
    end

    task automatic send_rotation(input quat_t qw, input quat_t qx, input quat_t qy,
                                 input quat_t qz, input vec_t vx, input vec_t vy,
                                 input vec_t vz, input bit allow_gap);
        @(negedge clk);
        while (allow_gap && $urandom_range(99) < GAP_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        quat_w <= qw;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        vec_x  <= vx;
        vec_y  <= vy;
        vec_z  <= vz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drain();
        while (chk.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic vec_t pick_vec(int mode);
        vec_t corner[5];
        corner[0] = vec_t'(VEC_MAX);
        corner[1] = vec_t'(VEC_MIN);
        corner[2] = '0;
        corner[3] = '1;
        corner[4] = vec_t'(1);
        case (mode)
            0:       return vec_t'($urandom_range(2000)) - vec_t'(1000);
            1:       return corner[$urandom_range(4)];
            default: return vec_t'($urandom);
        endcase
    endfunction

    task automatic random_item(input bit allow_gap);
        quat_t q[4];
        quat_t corner[6];
        real   a[4];
        real   norm;
        int    qmode;
        int    vmode;
        corner[0] = quat_t'(-32768);
        corner[1] = quat_t'(-32767);
        corner[2] = '1;
        corner[3] = '0;
        corner[4] = quat_t'(1);
        corner[5] = quat_t'(32767);
        qmode = $urandom_range(9);
        vmode = $urandom_range(5);
        norm = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = quat_t'($urandom);
            a[i] = real'(q[i]);
            norm = norm + a[i] * a[i];
        end
        if (qmode < 5 && norm > 0.0)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = quat_t'($rtoi(a[i] / $sqrt(norm) * 32767.0));
        end
        else if (qmode == 5)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = corner[$urandom_range(5)];
        end
        send_rotation(q[0], q[1], q[2], q[3], pick_vec(vmode % 3), pick_vec(vmode % 3),
                      pick_vec(vmode % 3), allow_gap);
    endtask

    initial
    begin
        vec_t vmax;
        vec_t vmin;
        vmax = vec_t'(VEC_MAX);
        vmin = vec_t'(VEC_MIN);
        rst_n  = 1'b0;
        start  = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        vec_x  = '0;
        vec_y  = '0;
        vec_z  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_rotation(32767, 0, 0, 0, 1000, -2000, 3000, 1'b0);
        send_rotation(-32768, 0, 0, 0, vmax, vmin, 1, 1'b0);
        send_rotation(0, 0, 0, 0, vmax, vmin, vmax, 1'b0);
        send_rotation(-32768, -32768, -32768, -32768, vmax, vmax, vmax, 1'b0);
        send_rotation(-32768, -32768, -32768, -32768, vmin, vmin, vmin, 1'b0);
        send_rotation(32767, 32767, 32767, 32767, vmin, vmax, 0, 1'b0);
        send_rotation(0, 0, 0, 16384, 1, -1, 3, 1'b0);
        send_rotation(0, 0, 0, 16384, -3, 5, -7, 1'b0);
        send_rotation(0, 32767, 0, 0, 123456, -654321, 7, 1'b0);
        send_rotation(23170, 0, 23170, 0, vmax, 0, vmin, 1'b0);
        send_rotation(23170, 0, 0, -23170, -1, -1, -1, 1'b0);
        send_rotation(0, 0, -32768, 0, vmin, vmin, vmin, 1'b0);
        send_rotation(16384, 16384, 16384, 16384, 4194304, -4194304, vmax, 1'b0);
        send_rotation(1, -1, 1, -1, 0, 0, 0, 1'b0);
        send_rotation(32767, -32768, 32767, -32768, vmax, vmin, vmax, 1'b0);
        send_rotation(-1, -1, -1, -1, -1, -1, -1, 1'b0);

        for (int k = 0; k < 1600; k++)
        begin
            if (k == 400 || k == 1200)
            begin
                @(negedge clk);
                start <= 1'b0;
                wait_drain();
            end
            random_item(k < 700 || k >= 1000);
        end
        @(negedge clk);
        start <= 1'b0;

        wait_drain();
        repeat (20) @(posedge clk);

        $display("Rotated %0d vectors (%0d expected to saturate) and checked %0d results.",
                 chk.transfers_in, chk.clip_count, chk.results_seen);
        $display("Mismatching or unexpected results: %0d.", chk.mismatches);
        if (chk.mismatches == 0 && chk.expected_q.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #500_000;
        $display("Timed out with %0d results still pending.", chk.expected_q.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_matrix.sv
rtl/core/qvr_mac.sv
rtl/core/qvr_round.sv
rtl/core/quaternion_vector_rotate.sv
tb/sv/testbench.sv
